/* hdl/ecpa_pkg.sv */
// Shared types, constants and field arithmetic for the affine point adder.
`default_nettype none

package ecpa_pkg;

    localparam int FIELD_BITS = 16;

    typedef logic [FIELD_BITS-1:0] field_t;

    typedef enum logic [0:0] {
        REG_PRIME   = 1'b0,
        REG_CURVE_A = 1'b1
    } cfg_reg_t;

    localparam field_t PRIME_RESET   = field_t'(101);
    localparam field_t CURVE_A_RESET = field_t'(2);

    typedef struct packed {
        field_t first_x;
        field_t first_y;
        field_t second_x;
        field_t second_y;
    } point_pair_t;

    typedef struct packed {
        field_t sum_x;
        field_t sum_y;
        logic   at_infinity;
    } point_sum_t;

    // operands below p
    function automatic field_t fadd(field_t a, field_t b, field_t p);
        logic [FIELD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[FIELD_BITS-1:0];
    endfunction

    function automatic field_t fsub(field_t a, field_t b, field_t p);
        field_t d;
        if (a >= b)
            d = a - b;
        else
            d = p - (b - a);
        return d;
    endfunction

    // one double-and-add step of the shift-add modular product
    function automatic field_t mul_step(field_t r, field_t a, logic bt, field_t p);
        field_t d;
        d = fadd(r, r, p);
        if (bt)
            d = fadd(d, a, p);
        return d;
    endfunction

endpackage

`default_nettype wire

/* hdl/ecpa_modmul.sv */
// Pipelined modular multiplier: one bit of b per stage, MSB first.
`default_nettype none

module ecpa_modmul #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ecpa_pkg::field_t    p,
    input  logic                in_valid,
    input  ecpa_pkg::field_t    a,
    input  ecpa_pkg::field_t    b,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output ecpa_pkg::field_t    prod,
    output logic [SIDE_W-1:0]   side_out
);
    import ecpa_pkg::*;

    localparam int STEPS = FIELD_BITS;

    logic              v_reg    [STEPS];
    field_t            r_reg    [STEPS];
    logic [SIDE_W-1:0] side_reg [STEPS];
    field_t            a_reg    [STEPS-1];
    field_t            b_reg    [STEPS-1];

    for (genvar k = 0; k < STEPS; k++) begin : g_stage
        if (k == 0) begin : g_first
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= in_valid;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]    <= mul_step('0, a, b[STEPS-1], p);
                    side_reg[k] <= side_in;
                end
            end

            if (STEPS > 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        a_reg[k] <= a;
                        b_reg[k] <= b;
                    end
                end
            end
        end else begin : g_next
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    v_reg[k] <= 1'b0;
                else if (en)
                    v_reg[k] <= v_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k]    <= mul_step(r_reg[k-1], a_reg[k-1],
                                            b_reg[k-1][STEPS-1-k], p);
                    side_reg[k] <= side_reg[k-1];
                end
            end

            if (k < STEPS - 1) begin : g_carry
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        a_reg[k] <= a_reg[k-1];
                        b_reg[k] <= b_reg[k-1];
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[STEPS-1];
    assign prod      = r_reg[STEPS-1];
    assign side_out  = side_reg[STEPS-1];

endmodule

`default_nettype wire

/* hdl/ecpa_inv.sv */
// Fermat inverse den^(p-2) mod p as a chain of square-and-multiply steps.
`default_nettype none

module ecpa_inv #(
    parameter int SIDE_W = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  ecpa_pkg::field_t    p,
    input  logic                in_valid,
    input  ecpa_pkg::field_t    den,
    input  logic [SIDE_W-1:0]   side_in,
    output logic                out_valid,
    output ecpa_pkg::field_t    inv,
    output logic [SIDE_W-1:0]   side_out
);
    import ecpa_pkg::*;

    localparam int STEPS = FIELD_BITS;

    field_t            e;
    logic              sv [STEPS+1];
    field_t            sr [STEPS+1];
    field_t            sb [STEPS];
    logic [SIDE_W-1:0] ss [STEPS+1];

    // user must keep exponent static while items are in flight; unchecked
    assign e = p - field_t'(2);

    assign sv[0] = in_valid;
    assign sr[0] = field_t'(1);
    assign sb[0] = den;
    assign ss[0] = side_in;

    for (genvar i = 0; i < STEPS; i++) begin : g_step
        field_t prod_r;
        field_t r_pass;

        if (i < STEPS - 1) begin : g_full
            ecpa_modmul #(.SIDE_W(SIDE_W)) u_mul (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .p        (p),
                .in_valid (sv[i]),
                .a        (sr[i]),
                .b        (sb[i]),
                .side_in  (ss[i]),
                .out_valid(sv[i+1]),
                .prod     (prod_r),
                .side_out (ss[i+1])
            );

            ecpa_modmul #(.SIDE_W(FIELD_BITS)) u_sqr (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .p        (p),
                .in_valid (sv[i]),
                .a        (sb[i]),
                .b        (sb[i]),
                .side_in  (sr[i]),
                .out_valid(),
                .prod     (sb[i+1]),
                .side_out (r_pass)
            );
        end else begin : g_last
            // base no longer needed after the top exponent bit
            ecpa_modmul #(.SIDE_W(SIDE_W + FIELD_BITS)) u_mul (
                .clk      (clk),
                .rst_n    (rst_n),
                .en       (en),
                .p        (p),
                .in_valid (sv[i]),
                .a        (sr[i]),
                .b        (sb[i]),
                .side_in  ({ss[i], sr[i]}),
                .out_valid(sv[i+1]),
                .prod     (prod_r),
                .side_out ({ss[i+1], r_pass})
            );
        end

        assign sr[i+1] = e[i] ? prod_r : r_pass;
    end

    assign out_valid = sv[STEPS];
    assign inv       = sr[STEPS];
    assign side_out  = ss[STEPS];

endmodule

`default_nettype wire

/* hdl/ec_affine_point_add.sv */
// Affine point addition on y^2 = x^3 + A*x + B over a prime field, fully pipelined.
// Takes one point pair every cycle while the result side is not stalled and returns one sum per pair,
// in order. Every modular product is a bit-serial shift-add pipeline of FIELD_BITS stages; the
// slope inverse is a Fermat chain of FIELD_BITS steps of such products, which sets most of the
// latency. Coordinates and A are reduced below p on entry. Equal x with y1+y2 = 0 gives
// at_infinity with zero coordinates; a modulus below three gives all zeros. prime_modulus and
// curve_a must only be written while no item is in flight. A stall on the result side while a
// sum is valid holds the whole pipeline.
`default_nettype none

module ec_affine_point_add (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  ecpa_pkg::cfg_reg_t      cfg_index,
    input  ecpa_pkg::field_t        cfg_data,
    input  logic                    pts_valid,
    output logic                    pts_stall,
    input  ecpa_pkg::point_pair_t   pts,
    output logic                    sum_valid,
    input  logic                    sum_stall,
    output ecpa_pkg::point_sum_t    sum
);
    import ecpa_pkg::*;

    localparam int N       = FIELD_BITS;
    localparam int SIDE2_W = 2 + 5 * N;
    localparam int SIDE4_W = 1 + 4 * N;
    localparam int SIDE5_W = 1 + 3 * N;
    localparam int SIDE7_W = 1 + 2 * N;

    field_t prime_reg;
    field_t curve_a_reg;
    logic   en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg   <= PRIME_RESET;
            curve_a_reg <= CURVE_A_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PRIME:   prime_reg   <= cfg_data;
                REG_CURVE_A: curve_a_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic       sum_valid_reg;
    point_sum_t sum_reg;

    assign en        = !(sum_valid_reg && sum_stall);
    assign pts_stall = !en;

    // reduction of inputs below p (product with one)
    logic   v1;
    field_t x1_1, y1_1, x2_1, y2_1, ca_1;

    ecpa_modmul #(.SIDE_W(1)) u_red_x1 (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(pts_valid),
        .a(field_t'(1)), .b(pts.first_x), .side_in(1'b0),
        .out_valid(v1), .prod(x1_1), .side_out()
    );
    ecpa_modmul #(.SIDE_W(1)) u_red_y1 (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(pts_valid),
        .a(field_t'(1)), .b(pts.first_y), .side_in(1'b0),
        .out_valid(), .prod(y1_1), .side_out()
    );
    ecpa_modmul #(.SIDE_W(1)) u_red_x2 (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(pts_valid),
        .a(field_t'(1)), .b(pts.second_x), .side_in(1'b0),
        .out_valid(), .prod(x2_1), .side_out()
    );
    ecpa_modmul #(.SIDE_W(1)) u_red_y2 (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(pts_valid),
        .a(field_t'(1)), .b(pts.second_y), .side_in(1'b0),
        .out_valid(), .prod(y2_1), .side_out()
    );
    ecpa_modmul #(.SIDE_W(1)) u_red_a (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(pts_valid),
        .a(field_t'(1)), .b(curve_a_reg), .side_in(1'b0),
        .out_valid(), .prod(ca_1), .side_out()
    );

    logic eqx_1, inf_1;
    assign eqx_1 = (x1_1 == x2_1);
    assign inf_1 = eqx_1 && (fadd(y1_1, y2_1, prime_reg) == '0);

    // x1^2
    logic               v2;
    field_t             sq_2;
    logic [SIDE2_W-1:0] side2;

    ecpa_modmul #(.SIDE_W(SIDE2_W)) u_sq (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(v1),
        .a(x1_1), .b(x1_1), .side_in({inf_1, eqx_1, ca_1, x1_1, y1_1, x2_1, y2_1}),
        .out_valid(v2), .prod(sq_2), .side_out(side2)
    );

    // 3*x1^2
    field_t             three;
    logic               v3;
    field_t             t3_3;
    logic [SIDE2_W-1:0] side3;
    logic               inf_3, eqx_3;
    field_t             ca_3, x1_3, y1_3, x2_3, y2_3;

    assign three = (prime_reg == field_t'(3)) ? '0 : field_t'(3);

    ecpa_modmul #(.SIDE_W(SIDE2_W)) u_t3 (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(v2),
        .a(three), .b(sq_2), .side_in(side2),
        .out_valid(v3), .prod(t3_3), .side_out(side3)
    );

    assign {inf_3, eqx_3, ca_3, x1_3, y1_3, x2_3, y2_3} = side3;

    // slope numerator and denominator: tangent on equal x, chord otherwise
    logic   sel_valid_reg;
    logic   sel_inf_reg;
    field_t sel_num_reg, sel_den_reg, sel_x1_reg, sel_x2_reg, sel_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_valid_reg <= 1'b0;
        else if (en)
            sel_valid_reg <= v3;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sel_num_reg <= eqx_3 ? fadd(t3_3, ca_3, prime_reg)
                                 : fsub(y2_3, y1_3, prime_reg);
            sel_den_reg <= eqx_3 ? fadd(y1_3, y1_3, prime_reg)
                                 : fsub(x2_3, x1_3, prime_reg);
            sel_inf_reg <= inf_3;
            sel_x1_reg  <= x1_3;
            sel_x2_reg  <= x2_3;
            sel_y1_reg  <= y1_3;
        end
    end

    // inverse of the denominator
    logic               v4;
    field_t             inv_4;
    logic [SIDE4_W-1:0] side4;
    logic               inf_4;
    field_t             num_4, x1_4, x2_4, y1_4;

    ecpa_inv #(.SIDE_W(SIDE4_W)) u_inv (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(sel_valid_reg),
        .den(sel_den_reg),
        .side_in({sel_inf_reg, sel_num_reg, sel_x1_reg, sel_x2_reg, sel_y1_reg}),
        .out_valid(v4), .inv(inv_4), .side_out(side4)
    );

    assign {inf_4, num_4, x1_4, x2_4, y1_4} = side4;

    // slope
    logic               v5;
    field_t             s_5;
    logic [SIDE5_W-1:0] side5;

    ecpa_modmul #(.SIDE_W(SIDE5_W)) u_slope (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(v4),
        .a(num_4), .b(inv_4), .side_in({inf_4, x1_4, x2_4, y1_4}),
        .out_valid(v5), .prod(s_5), .side_out(side5)
    );

    // slope squared
    logic                 v6;
    field_t               ss_6;
    logic [SIDE4_W-1:0]   side6;
    logic                 inf_6;
    field_t               s_6, x1_6, x2_6, y1_6;

    ecpa_modmul #(.SIDE_W(SIDE4_W)) u_slope_sq (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(v5),
        .a(s_5), .b(s_5), .side_in({side5[SIDE5_W-1], s_5, side5[SIDE5_W-2:0]}),
        .out_valid(v6), .prod(ss_6), .side_out(side6)
    );

    assign {inf_6, s_6, x1_6, x2_6, y1_6} = side6;

    // x3 = s^2 - x1 - x2
    logic   x3_valid_reg;
    logic   x3_inf_reg;
    field_t x3_s_reg, x3_x1_reg, x3_x3_reg, x3_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            x3_valid_reg <= 1'b0;
        else if (en)
            x3_valid_reg <= v6;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x3_x3_reg  <= fsub(fsub(ss_6, x1_6, prime_reg), x2_6, prime_reg);
            x3_inf_reg <= inf_6;
            x3_s_reg   <= s_6;
            x3_x1_reg  <= x1_6;
            x3_y1_reg  <= y1_6;
        end
    end

    // x1 - x3
    logic   d_valid_reg;
    logic   d_inf_reg;
    field_t d_s_reg, d_d_reg, d_x3_reg, d_y1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= x3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_d_reg   <= fsub(x3_x1_reg, x3_x3_reg, prime_reg);
            d_inf_reg <= x3_inf_reg;
            d_s_reg   <= x3_s_reg;
            d_x3_reg  <= x3_x3_reg;
            d_y1_reg  <= x3_y1_reg;
        end
    end

    // s*(x1 - x3)
    logic               v7;
    field_t             sy_7;
    logic [SIDE7_W-1:0] side7;
    logic               inf_7;
    field_t             x3_7, y1_7;

    ecpa_modmul #(.SIDE_W(SIDE7_W)) u_ymul (
        .clk(clk), .rst_n(rst_n), .en(en), .p(prime_reg), .in_valid(d_valid_reg),
        .a(d_s_reg), .b(d_d_reg), .side_in({d_inf_reg, d_x3_reg, d_y1_reg}),
        .out_valid(v7), .prod(sy_7), .side_out(side7)
    );

    assign {inf_7, x3_7, y1_7} = side7;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sum_valid_reg <= 1'b0;
        else if (en)
            sum_valid_reg <= v7;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (prime_reg < field_t'(3))
            begin
                sum_reg.sum_x       <= '0;
                sum_reg.sum_y       <= '0;
                sum_reg.at_infinity <= 1'b0;
            end
            else if (inf_7)
            begin
                sum_reg.sum_x       <= '0;
                sum_reg.sum_y       <= '0;
                sum_reg.at_infinity <= 1'b1;
            end
            else
            begin
                sum_reg.sum_x       <= x3_7;
                sum_reg.sum_y       <= fsub(sy_7, y1_7, prime_reg);
                sum_reg.at_infinity <= 1'b0;
            end
        end
    end

    assign sum_valid = sum_valid_reg;
    assign sum       = sum_reg;

    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && sum.at_infinity |-> sum.sum_x == '0 && sum.sum_y == '0)
        else $error("point at infinity with nonzero coordinates");

    a_small_mod: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && prime_reg < field_t'(3) |-> !sum.at_infinity && sum.sum_x == '0)
        else $error("degenerate modulus gave a nonzero result");

    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        sum_valid && prime_reg >= field_t'(3) |-> sum.sum_x < prime_reg && sum.sum_y < prime_reg)
        else $error("sum not reduced below modulus");

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for the pipelined affine point adder.
`default_nettype none

module testbench;
    import ecpa_pkg::*;

    localparam int LATENCY = 356;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 600;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    cfg_reg_t    cfg_index;
    field_t      cfg_data;
    logic        pts_valid = 1'b0;
    logic        pts_stall;
    point_pair_t pts = '0;
    logic        sum_valid;
    logic        sum_stall = 1'b0;
    point_sum_t  sum;

    ec_affine_point_add dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .pts_valid(pts_valid), .pts_stall(pts_stall), .pts(pts),
        .sum_valid(sum_valid), .sum_stall(sum_stall), .sum(sum)
    );

    // shadow copy of the configuration
    longint unsigned modulus;
    longint unsigned coeff_a;

    point_pair_t pair_queue[$];
    point_sum_t  sum_queue[$];
    int          fail_count = 0;
    longint      cycle_count = 0;
    bit          calm;             // no random idling
    bit          hold_req;         // long receiver stall requested
    bit          hold_done = 1'b0;
    int          hold_count = 0;
    logic        pts_stall_at_edge;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint unsigned m_add(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
        longint unsigned s;
        s = a + b;
        if (s >= p)
            s = s - p;
        return s;
    endfunction

    function automatic longint unsigned m_sub(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
        return (a >= b) ? a - b : p - (b - a);
    endfunction

    function automatic longint unsigned m_mul(longint unsigned a, longint unsigned b,
                                              longint unsigned p);
        return (a * b) % p;
    endfunction

    function automatic longint unsigned m_pow(longint unsigned b, longint unsigned e,
                                              longint unsigned p);
        longint unsigned r;
        r = 1 % p;
        while (e != 0)
        begin
            if (e[0])
                r = m_mul(r, b, p);
            b = m_mul(b, b, p);
            e = e >> 1;
        end
        return r;
    endfunction

    function automatic point_sum_t add_points(point_pair_t pr);
        point_sum_t res;
        longint unsigned p, x1, y1, x2, y2, num, den, s, x3, y3;
        res = '0;
        p = modulus;
        if (p < 3)
            return res;
        x1 = pr.first_x % p;
        y1 = pr.first_y % p;
        x2 = pr.second_x % p;
        y2 = pr.second_y % p;
        if (x1 == x2 && m_add(y1, y2, p) == 0)
        begin
            res.at_infinity = 1'b1;
            return res;
        end
        if (x1 != x2)
        begin
            num = m_sub(y2, y1, p);
            den = m_sub(x2, x1, p);
        end
        else
        begin
            num = m_add(m_mul(3 % p, m_mul(x1, x1, p), p), coeff_a % p, p);
            den = m_mul(2, y1, p);
        end
        s = m_mul(num, m_pow(den, p - 2, p), p);
        x3 = m_sub(m_sub(m_mul(s, s, p), x1, p), x2, p);
        y3 = m_sub(m_mul(s, m_sub(x1, x3, p), p), y1, p);
        res.sum_x = field_t'(x3);
        res.sum_y = field_t'(y3);
        return res;
    endfunction

    // driver: offers the head of the pending queue, changes inputs on the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pts_valid && !pts_stall_at_edge)
            begin
                void'(pair_queue.pop_front());
            end
            if (pts_valid && pts_stall_at_edge)
            begin
                // stalled item stays on offer unchanged
            end
            else if (pair_queue.size() != 0 && (calm || $urandom_range(99) >= 31))
            begin
                pts_valid <= 1'b1;
                pts       <= pair_queue[0];
            end
            else
            begin
                pts_valid <= 1'b0;
                pts       <= point_pair_t'({$urandom, $urandom});
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req && !hold_done)
            begin
                sum_stall  <= 1'b1;
                hold_count <= hold_count + 1;
                if (hold_count == HOLD_CYCLES - 1)
                    hold_done <= 1'b1;
            end
            else
                sum_stall <= !calm && ($urandom_range(99) < 31);
        end
    end

    // acceptance seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pts_stall_at_edge <= 1'b1;
        end
        else
        begin
            pts_stall_at_edge <= pts_stall;
            if (pts_valid && !pts_stall)
            begin
                sum_queue = {sum_queue, add_points(pts)};
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        point_sum_t want;
        cycle_count <= cycle_count + 1;
        if (rst_n && sum_valid && !sum_stall)
        begin
            if (sum_queue.size() == 0)
            begin
                $error("result with nothing expected: %h", sum);
                fail_count <= fail_count + 1;
            end
            else
            begin
                want = sum_queue.pop_front();
                if (sum.sum_x !== want.sum_x)
                begin
                    $error("sum_x expected %0d got %0d", want.sum_x, sum.sum_x);
                    fail_count <= fail_count + 1;
                end
                if (sum.sum_y !== want.sum_y)
                begin
                    $error("sum_y expected %0d got %0d", want.sum_y, sum.sum_y);
                    fail_count <= fail_count + 1;
                end
                if (sum.at_infinity !== want.at_infinity)
                begin
                    $error("at_infinity expected %0d got %0d", want.at_infinity,
                           sum.at_infinity);
                    fail_count <= fail_count + 1;
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, field_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PRIME)
            modulus = val;
        else
            coeff_a = val;
    endtask

    task automatic drain;
        while (pair_queue.size() != 0 || sum_queue.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 20) @(posedge clk);
    endtask

    function automatic field_t pick(longint unsigned p);
        case ($urandom_range(9))
            0: return '0;
            1: return field_t'(p - 1);
            2: return field_t'($urandom);   // may be unreduced
            default: return field_t'($urandom_range(32'(p - 1)));
        endcase
    endfunction

    // about half the pairs get structure: equal x, negated y, doubling
    task automatic queue_random(int count);
        point_pair_t pr;
        longint unsigned p;
        p = modulus < 3 ? 101 : modulus;
        repeat (count)
        begin
            pr.first_x  = pick(p);
            pr.first_y  = pick(p);
            pr.second_x = pick(p);
            pr.second_y = pick(p);
            case ($urandom_range(5))
                0: pr.second_x = pr.first_x;
                1:
                begin
                    pr.second_x = pr.first_x;
                    pr.second_y = field_t'(m_sub(0, pr.first_y % p, p));
                end
                2:
                begin
                    pr.second_x = pr.first_x;
                    pr.second_y = pr.first_y;
                end
                default: ;
            endcase
            pair_queue = {pair_queue, pr};
        end
    endtask

    task automatic queue_pair(field_t a, field_t b, field_t c, field_t d);
        pair_queue = {pair_queue, point_pair_t'{a, b, c, d}};
    endtask

    initial
    begin
        clk        = 1'b0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_PRIME;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        modulus    = PRIME_RESET;
        coeff_a    = CURVE_A_RESET;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset configuration
        queue_pair(16'd0, 16'd0, 16'd0, 16'd0);      // doubling with y = 0: infinity, inverts zero
        queue_pair(16'd3, 16'd7, 16'd3, 16'd94);     // negated y: infinity
        queue_pair(16'd5, 16'd1, 16'd9, 16'd20);     // chord
        queue_pair(16'd5, 16'd1, 16'd5, 16'd1);      // tangent
        queue_pair(16'd5, 16'd1, 16'd5, 16'd30);     // equal x, other y
        queue_pair(16'd100, 16'd100, 16'd0, 16'd0);
        queue_pair(16'hffff, 16'hffff, 16'h0000, 16'hffff);  // unreduced
        queue_pair(16'haaaa, 16'h5555, 16'h5555, 16'haaaa);
        drain();

        write_reg(REG_PRIME, 16'd65521);
        write_reg(REG_CURVE_A, 16'd65520);
        queue_pair(16'd65520, 16'd65520, 16'd0, 16'd1);
        queue_pair(16'd65520, 16'd1, 16'd65520, 16'd65520);
        queue_pair(16'd1234, 16'd4321, 16'd1234, 16'd4321);
        queue_pair(16'hffff, 16'hfff0, 16'hfff1, 16'h0001);
        drain();

        write_reg(REG_PRIME, 16'd2);       // modulus below three
        queue_pair(16'd1, 16'd1, 16'd0, 16'd1);
        drain();
        write_reg(REG_PRIME, 16'd15);      // not prime
        write_reg(REG_CURVE_A, 16'hffff);
        queue_pair(16'd3, 16'd4, 16'd8, 16'd2);
        queue_pair(16'd6, 16'd6, 16'd6, 16'd6);
        drain();
        write_reg(REG_PRIME, 16'd3);
        write_reg(REG_CURVE_A, 16'd0);
        queue_pair(16'd2, 16'd1, 16'd2, 16'd1);
        queue_pair(16'd1, 16'd2, 16'd2, 16'd1);
        drain();

        // random phases, one with a long result-side hold-off that stalls the pipeline
        write_reg(REG_PRIME, 16'd65521);
        write_reg(REG_CURVE_A, field_t'($urandom));
        queue_random(400);
        hold_req = 1'b1;
        wait (hold_done);
        hold_req = 1'b0;
        drain();

        write_reg(REG_PRIME, 16'd101);
        write_reg(REG_CURVE_A, 16'd2);
        calm = 1'b1;
        queue_random(150);
        drain();
        calm = 1'b0;

        write_reg(REG_PRIME, 16'd40961);
        write_reg(REG_CURVE_A, 16'd0);
        queue_random(150);
        drain();

        write_reg(REG_PRIME, 16'd7);
        write_reg(REG_CURVE_A, 16'd6);
        queue_random(80);
        drain();

        write_reg(REG_PRIME, 16'd65535);   // not prime
        write_reg(REG_CURVE_A, 16'hffff);
        queue_random(60);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule

`default_nettype wire
